>>> hdl/mprb_pkg.sv
package mprb_pkg;

	typedef enum logic [1:0] {
		REQ_ACQUIRE = 2'd0,
		REQ_CLOSE   = 2'd1,
		REQ_WRITE   = 2'd2,
		REQ_READ    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_REFUSE = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	localparam int MAX_RUN = 64;
	localparam int LEN_W = 7;

	typedef struct packed {
		req_t             req;
		logic             any_port;
		logic [3:0]       port;
		logic [7:0]       owner;
		logic [7:0]       data;
		logic [LEN_W-1:0] len;
	} cmd_t;

endpackage

>>> hdl/mprb_front.sv
module mprb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mprb_pkg::cmd_t   in_cmd,
	output logic             q_valid,
	input  logic             q_ready,
	output mprb_pkg::cmd_t   q_cmd
);

	mprb_pkg::cmd_t slot_q [2];
	mprb_pkg::cmd_t in_clamped;
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = slot_q[rd_q];

	always_comb begin
		in_clamped = in_cmd;
		if (in_cmd.len > mprb_pkg::LEN_W'(mprb_pkg::MAX_RUN)) begin
			in_clamped.len = mprb_pkg::LEN_W'(mprb_pkg::MAX_RUN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= in_clamped;
		end
	end

endmodule

>>> hdl/mprb_back.sv
module mprb_back #(
	parameter int PORT_COUNT = 16,
	parameter int BUF_DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [15:0]      mask,
	input  logic             q_valid,
	output logic             q_ready,
	input  mprb_pkg::cmd_t   q_cmd,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [3:0]       result_port,
	output logic [7:0]       read_byte,
	output logic             last
);

	localparam int PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int CW = $clog2(BUF_DEPTH + 1);
	localparam int SP = (PORT_COUNT < 16) ? PORT_COUNT : 16;

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t state_q;
	logic [7:0] mem [PORT_COUNT*(2**AW)];
	logic [AW-1:0] head_q [PORT_COUNT];
	logic [AW-1:0] tail_q [PORT_COUNT];
	logic [CW-1:0] fill_q [PORT_COUNT];
	logic [PORT_COUNT-1:0] used_q;
	logic [7:0] owner_q [PORT_COUNT];
	logic [7:0] rdata_q;
	logic [PW-1:0] rport_q;
	logic [3:0] rport4_q;
	logic [mprb_pkg::LEN_W-1:0] left_q;
	logic pend_q;
	logic [PORT_COUNT-1:0] res;

	logic [PW-1:0] p;
	logic pvalid, rsv, opn;
	logic found;
	logic [PW-1:0] fidx;
	logic out_free;
	logic take, emit;
	mprb_pkg::status_t dec_status;
	logic [3:0] dec_port;
	logic do_claim, do_free, do_write, start_rd;
	logic [PW-1:0] tp;
	logic [mprb_pkg::LEN_W-1:0] run_len;

	assign p = PW'(q_cmd.port);
	assign pvalid = ({2'b0, q_cmd.port} < 6'(PORT_COUNT)) || (PORT_COUNT >= 16);

	always_comb begin
		for (int i = 0; i < PORT_COUNT; i++) begin
			res[i] = (i < 16) ? mask[i % 16] : 1'b0;
		end
		rsv = pvalid && res[p];
		opn = pvalid && (res[p] || used_q[p]);
		found = 1'b0;
		fidx = '0;
		for (int i = SP - 1; i >= 0; i--) begin
			if (!res[i] && !used_q[i]) begin
				found = 1'b1;
				fidx = PW'(i);
			end
		end
	end

	assign out_free = !out_valid || out_ready;
	assign q_ready = (state_q == S_IDLE) && out_free;
	assign take = q_valid && q_ready;
	assign emit = (state_q == S_RUN) && pend_q && out_free;

	always_comb begin
		dec_status = mprb_pkg::ST_OK;
		dec_port = q_cmd.port;
		do_claim = 1'b0;
		do_free = 1'b0;
		do_write = 1'b0;
		start_rd = 1'b0;
		tp = p;
		run_len = q_cmd.len;
		case (q_cmd.req)
			mprb_pkg::REQ_ACQUIRE: begin
				if (q_cmd.any_port) begin
					if (found) begin
						do_claim = 1'b1;
						tp = fidx;
						dec_port = 4'(fidx);
					end else begin
						dec_status = mprb_pkg::ST_REFUSE;
						dec_port = 4'd0;
					end
				end else if (!pvalid || rsv || used_q[p]) begin
					dec_status = mprb_pkg::ST_REFUSE;
				end else begin
					do_claim = 1'b1;
				end
			end
			mprb_pkg::REQ_CLOSE: begin
				if (!pvalid || rsv || !used_q[p]) begin
					dec_status = mprb_pkg::ST_REFUSE;
				end else begin
					do_free = 1'b1;
				end
			end
			mprb_pkg::REQ_WRITE: begin
				if (!opn) begin
					dec_status = mprb_pkg::ST_REFUSE;
				end else if (fill_q[p] >= CW'(BUF_DEPTH)) begin
					dec_status = mprb_pkg::ST_FULL;
				end else begin
					do_write = 1'b1;
				end
			end
			default: begin
				if (q_cmd.len == '0) begin
					dec_status = mprb_pkg::ST_OK;
				end else if (!opn) begin
					dec_status = mprb_pkg::ST_REFUSE;
				end else if (fill_q[p] == '0) begin
					dec_status = mprb_pkg::ST_EMPTY;
				end else begin
					start_rd = 1'b1;
					if ({1'b0, q_cmd.len} > (mprb_pkg::LEN_W + 1)'(fill_q[p])) begin
						run_len = mprb_pkg::LEN_W'(fill_q[p]);
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			status <= '0;
			result_port <= '0;
			read_byte <= '0;
			last <= 1'b0;
			used_q <= '0;
			pend_q <= 1'b0;
			rport_q <= '0;
			rport4_q <= '0;
			left_q <= '0;
			for (int i = 0; i < PORT_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
				owner_q[i] <= '0;
			end
		end else begin
			if (take) begin
				out_valid <= !start_rd;
				status <= dec_status;
				result_port <= dec_port;
				read_byte <= 8'd0;
				last <= 1'b1;
			end else if (emit) begin
				out_valid <= 1'b1;
				status <= mprb_pkg::ST_OK;
				result_port <= rport4_q;
				read_byte <= rdata_q;
				last <= (left_q == '0);
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take) begin
						if (do_claim || do_free) begin
							used_q[tp] <= do_claim;
							owner_q[tp] <= do_claim ? q_cmd.owner : 8'd0;
							head_q[tp] <= '0;
							tail_q[tp] <= '0;
							fill_q[tp] <= '0;
						end
						if (do_write) begin
							head_q[p] <= (head_q[p] == AW'(BUF_DEPTH - 1)) ? '0
								: head_q[p] + AW'(1);
							fill_q[p] <= fill_q[p] + CW'(1);
						end
						if (start_rd) begin
							rport_q <= p;
							rport4_q <= q_cmd.port;
							left_q <= run_len;
							pend_q <= 1'b0;
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (emit) begin
						pend_q <= 1'b0;
						if (left_q == '0) begin
							state_q <= S_IDLE;
						end
					end else if (!pend_q) begin
						pend_q <= 1'b1;
						left_q <= left_q - mprb_pkg::LEN_W'(1);
						fill_q[rport_q] <= fill_q[rport_q] - CW'(1);
						tail_q[rport_q] <= (tail_q[rport_q] == AW'(BUF_DEPTH - 1)) ? '0
							: tail_q[rport_q] + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && do_write) begin
			mem[{p, head_q[p]}] <= q_cmd.data;
		end
		if (state_q == S_RUN && !pend_q) begin
			rdata_q <= mem[{rport_q, tail_q[rport_q]}];
		end
	end

endmodule

>>> hdl/multi_port_ring_buffer_manager_unit.sv
// Acquire, close and write requests give their one result, registered in the back end after leaving the queue.
// A read of n bytes yields at most n bytes, each fetched from the ring memory before it is emitted.
// A two-entry queue separates intake from execution, so intake runs ahead of a long read.
// Asynchronous reset frees all ports, empties all rings and sets the reserved mask to 7.
// Ring contents are not cleared by reset.
module multi_port_ring_buffer_manager_unit #(
	parameter int PORT_COUNT = 16,
	parameter int BUF_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic        any_port,
	input  logic [3:0]  port_num,
	input  logic [7:0]  owner_id,
	input  logic [7:0]  data_byte,
	input  logic [6:0]  read_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [3:0]  result_port,
	output logic [7:0]  read_byte,
	output logic        last
);

	logic [15:0] mask_q;
	mprb_pkg::cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 16'd7;
		end else if (cfg_we) begin
			mask_q <= cfg_wdata;
		end
	end

	always_comb begin
		in_cmd.req = mprb_pkg::req_t'(req_type);
		in_cmd.any_port = any_port;
		in_cmd.port = port_num;
		in_cmd.owner = owner_id;
		in_cmd.data = data_byte;
		in_cmd.len = read_len;
	end

	mprb_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	mprb_back #(.PORT_COUNT(PORT_COUNT), .BUF_DEPTH(BUF_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .mask(mask_q), .q_valid(q_valid), .q_ready(q_ready),
		.q_cmd(q_cmd), .out_valid(out_valid), .out_ready(out_ready), .status(status),
		.result_port(result_port), .read_byte(read_byte), .last(last)
	);

endmodule
